[rtl/mbrtu_pkg.sv]
// ----------------------------------------------------------------------------
// mbrtu_pkg
// shared constants, types and the crc-16 byte update for the rtu receiver
// ----------------------------------------------------------------------------
package mbrtu_pkg;

  // longest frame the byte counter tracks before it saturates
  localparam int MAX_FRAME = 256;
  localparam int CNT_W     = $clog2(MAX_FRAME + 1);

  // decoupling queue between the frame front end and the result sequencer
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // configuration port
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TICKS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAME  = CFG_IDX_W'(3);

  // verdict status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_CRC_ERR   = 3'd1;
  localparam logic [2:0] STAT_ILLEGAL   = 3'd2;
  localparam logic [2:0] STAT_TOO_SHORT = 3'd3;
  localparam logic [2:0] STAT_FRAMING   = 3'd4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // one finished frame, handed from the front end to the sequencer
  typedef struct packed {
    logic [2:0]       status;
    logic [7:0]       func;
    logic [CNT_W-1:0] len;
    logic [7:0]       addr;
    logic             bcast;
    logic             reply;
  } verdict_t;

  // reflected crc-16/modbus, one byte
  function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[rtl/mbrtu_front.sv]
// ----------------------------------------------------------------------------
// mbrtu_front
// frame tracking: silence counter, address filter, byte count, crc, verdict
// ----------------------------------------------------------------------------
module mbrtu_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            item_valid,
  input  logic                            command,
  input  logic [7:0]                      rx_byte,
  input  logic                            cfg_we,
  input  logic [mbrtu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data,
  output logic                            push,
  output mbrtu_pkg::verdict_t             entry
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RECV,
    ST_RERR,
    ST_SKIP
  } run_state_t;

  localparam int CW = mbrtu_pkg::CNT_W;
  localparam logic [CW-1:0] CNT_MAX = CW'(mbrtu_pkg::MAX_FRAME);

  run_state_t    state_r, state_nxt;
  logic [7:0]    silence_r, silence_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic [7:0]    addr_r, addr_nxt;
  logic [7:0]    func_r, func_nxt;

  logic [7:0] slave_addr_r, idle_ticks_r, gap_ticks_r, min_frame_r;

  logic       frame_end;
  logic [2:0] status;
  logic       bcast;
  logic [15:0] crc_byte;

  assign bcast    = (addr_r == 8'h00);
  assign crc_byte = mbrtu_pkg::crc16_update((state_r == ST_IDLE) ? mbrtu_pkg::CRC_INIT : crc_r,
                                            rx_byte);

  always_comb begin
    if (cnt_r <= {1'b0, min_frame_r}) begin
      status = mbrtu_pkg::STAT_TOO_SHORT;
    end else if (crc_r != 16'h0000) begin
      status = mbrtu_pkg::STAT_CRC_ERR;
    end else if (func_r inside {8'h03, 8'h06, 8'h10}) begin
      status = mbrtu_pkg::STAT_OK;
    end else begin
      status = mbrtu_pkg::STAT_ILLEGAL;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    silence_nxt = silence_r;
    cnt_nxt     = cnt_r;
    crc_nxt     = crc_r;
    addr_nxt    = addr_r;
    func_nxt    = func_r;
    frame_end   = 1'b0;
    if (item_valid) begin
      if (command) begin
        silence_nxt = 8'h00;
        case (state_r)
          ST_IDLE: begin
            if (rx_byte == slave_addr_r || rx_byte == 8'h00) begin
              state_nxt = ST_RECV;
              cnt_nxt   = CW'(1);
              crc_nxt   = crc_byte;
              addr_nxt  = rx_byte;
              func_nxt  = 8'h00;
            end else begin
              state_nxt = ST_SKIP;
            end
          end
          ST_RECV: begin
            // gap is the silence seen before this byte
            if (cnt_r < CNT_MAX && silence_r < gap_ticks_r) begin
              if (cnt_r == CW'(1)) begin
                func_nxt = rx_byte;
              end
              crc_nxt = crc_byte;
            end else begin
              state_nxt = ST_RERR;
            end
            if (cnt_r < CNT_MAX) begin
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          default: ;
        endcase
      end else if (state_r != ST_IDLE) begin
        if (silence_r < idle_ticks_r) begin
          silence_nxt = silence_r + 8'd1;
        end else begin
          frame_end = 1'b1;
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end
      end
    end
  end

  assign push = frame_end && (state_r == ST_RECV || state_r == ST_RERR);

  always_comb begin
    entry.func  = func_r;
    entry.len   = cnt_r;
    entry.addr  = addr_r;
    entry.bcast = bcast;
    if (state_r == ST_RERR) begin
      entry.status = mbrtu_pkg::STAT_FRAMING;
      entry.reply  = 1'b0;
    end else begin
      entry.status = status;
      entry.reply  = (status == mbrtu_pkg::STAT_ILLEGAL) && !bcast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      silence_r    <= 8'h00;
      cnt_r        <= '0;
      crc_r        <= mbrtu_pkg::CRC_INIT;
      addr_r       <= 8'h00;
      func_r       <= 8'h00;
      slave_addr_r <= 8'd1;
      idle_ticks_r <= 8'd4;
      gap_ticks_r  <= 8'd2;
      min_frame_r  <= 8'd4;
    end else begin
      state_r   <= state_nxt;
      silence_r <= silence_nxt;
      cnt_r     <= cnt_nxt;
      crc_r     <= crc_nxt;
      addr_r    <= addr_nxt;
      func_r    <= func_nxt;
      if (cfg_we) begin
        case (cfg_index)
          mbrtu_pkg::REG_SLAVE_ADDR: slave_addr_r <= cfg_data;
          mbrtu_pkg::REG_IDLE_TICKS: idle_ticks_r <= cfg_data;
          mbrtu_pkg::REG_GAP_TICKS:  gap_ticks_r  <= cfg_data;
          mbrtu_pkg::REG_MIN_FRAME:  min_frame_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // an idle receiver has no bytes counted
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> cnt_r == '0)
    else $error("idle with nonzero byte count");

  // byte count saturates at the frame limit
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("byte count past frame limit");

  // a frame end always leaves the receiver idle
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    frame_end |=> state_r == ST_IDLE)
    else $error("frame end did not return to idle");

endmodule

[rtl/mbrtu_queue.sv]
// ----------------------------------------------------------------------------
// mbrtu_queue
// small register queue of frame verdicts between front end and sequencer
// ----------------------------------------------------------------------------
module mbrtu_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mbrtu_pkg::verdict_t push_data,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output mbrtu_pkg::verdict_t head
);

  localparam int AW = mbrtu_pkg::Q_AW;

  mbrtu_pkg::verdict_t slot_r [mbrtu_pkg::Q_DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == (AW+1)'(mbrtu_pkg::Q_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and count agree modulo the depth
  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == count_r[AW-1:0])
    else $error("queue pointers disagree with count");

  // the front end never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push while queue full");

  // occupancy stays within the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (AW+1)'(mbrtu_pkg::Q_DEPTH))
    else $error("queue count past depth");

endmodule

[rtl/mbrtu_back.sv]
// ----------------------------------------------------------------------------
// mbrtu_back
// result sequencer: verdict beat, then exception reply bytes with crc
// ----------------------------------------------------------------------------
module mbrtu_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty,
  input  mbrtu_pkg::verdict_t      head,
  output logic                     q_pop,
  input  logic                     out_pop,
  output logic                     out_empty,
  output logic                     out_kind,
  output logic [2:0]               out_status,
  output logic [7:0]               out_function_code,
  output logic [8:0]               out_frame_length,
  output logic                     out_broadcast,
  output logic [7:0]               out_tx_byte,
  output logic                     out_last
);

  localparam logic [2:0] BEAT_VERDICT = 3'd0;
  localparam logic [2:0] BEAT_ADDR    = 3'd1;
  localparam logic [2:0] BEAT_FUNC    = 3'd2;
  localparam logic [2:0] BEAT_CODE    = 3'd3;
  localparam logic [2:0] BEAT_CRC_LO  = 3'd4;
  localparam logic [2:0] BEAT_CRC_HI  = 3'd5;

  localparam logic [7:0] EXC_FLAG         = 8'h80;
  localparam logic [7:0] EXC_ILLEGAL_FUNC = 8'h01;

  logic [2:0]  beat_r, beat_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        valid_r, valid_nxt;
  logic        load, last_beat;
  logic [7:0]  tx;

  logic        kind_r, bcast_r, last_r;
  logic [2:0]  status_r;
  logic [7:0]  func_r, tx_r;
  logic [8:0]  len_r;

  assign load      = !q_empty && (!valid_r || out_pop);
  assign last_beat = head.reply ? (beat_r == BEAT_CRC_HI) : 1'b1;
  assign q_pop     = load && last_beat;

  always_comb begin
    case (beat_r)
      BEAT_ADDR:   tx = head.addr;
      BEAT_FUNC:   tx = head.func | EXC_FLAG;
      BEAT_CODE:   tx = EXC_ILLEGAL_FUNC;
      BEAT_CRC_LO: tx = crc_r[7:0];
      BEAT_CRC_HI: tx = crc_r[15:8];
      default:     tx = 8'h00;
    endcase
  end

  always_comb begin
    beat_nxt  = beat_r;
    crc_nxt   = crc_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      beat_nxt  = last_beat ? BEAT_VERDICT : beat_r + 3'd1;
      if (beat_r inside {BEAT_ADDR, BEAT_FUNC, BEAT_CODE}) begin
        crc_nxt = mbrtu_pkg::crc16_update((beat_r == BEAT_ADDR) ? mbrtu_pkg::CRC_INIT : crc_r,
                                          tx);
      end
    end else if (out_pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r  <= BEAT_VERDICT;
      valid_r <= 1'b0;
      crc_r   <= mbrtu_pkg::CRC_INIT;
    end else begin
      beat_r  <= beat_nxt;
      valid_r <= valid_nxt;
      crc_r   <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r   <= (beat_r != BEAT_VERDICT);
      status_r <= (beat_r == BEAT_VERDICT) ? head.status : mbrtu_pkg::STAT_ILLEGAL;
      func_r   <= head.func;
      len_r    <= 9'(head.len);
      bcast_r  <= (beat_r == BEAT_VERDICT) ? head.bcast : 1'b0;
      tx_r     <= tx;
      last_r   <= last_beat;
    end
  end

  assign out_empty         = !valid_r;
  assign out_kind          = kind_r;
  assign out_status        = status_r;
  assign out_function_code = func_r;
  assign out_frame_length  = len_r;
  assign out_broadcast     = bcast_r;
  assign out_tx_byte       = tx_r;
  assign out_last          = last_r;

  // mid-reply the frame stays at the queue head
  a_reply_held: assert property (@(posedge clk) disable iff (!rst_n)
    beat_r != BEAT_VERDICT |-> !q_empty && head.reply)
    else $error("reply in progress without its frame");

  // the beat index never runs past the crc high byte
  a_beat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    beat_r <= BEAT_CRC_HI)
    else $error("beat index out of range");

  // reply bytes carry the illegal function status and no broadcast flag
  a_reply_fields: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && kind_r |-> status_r == mbrtu_pkg::STAT_ILLEGAL && !bcast_r)
    else $error("reply byte with wrong status");

endmodule

[rtl/modbus_rtu_slave_framer.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_slave_framer
// modbus rtu slave receive framer with verdicts and exception replies
// ----------------------------------------------------------------------------
// usage
//   input channel: one beat per timer tick (in_command 0) or received byte
//   (in_command 1, value on in_rx_byte); a beat moves when in_push is high and
//   in_full is low. bytes and ticks are taken every cycle while in_full is low.
//   result channel: a queue view; while out_empty is low the oldest result is
//   on the out_ ports and out_pop takes it. the ending tick of an addressed
//   frame gives one verdict beat, or a verdict plus five exception reply beats
//   (address, function|0x80, code 1, crc low, crc high) for an unsupported
//   function on a unicast frame; out_last marks the final beat of that tick.
//   config: cfg_valid/cfg_ready write cfg_data to register cfg_index (0 slave
//   address, 1 idle ticks, 2 gap ticks, 3 min frame bytes); always ready.
//   timing: a verdict passes the queue, then the output register; reply beats
//   follow one per cycle while popped. the frame logic takes one beat a cycle
//   while in_full is low, the crc of a received byte is done in that same cycle.
//   reset: synchronous, registers back to their defaults, queue and output
//   stage empty.
//   stall: results wait in a 4-deep verdict queue plus an output register;
//   in_full rises only once that queue is full.
// ----------------------------------------------------------------------------
module modbus_rtu_slave_framer (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_push,
  output logic                            in_full,
  input  logic                            in_command,
  input  logic [7:0]                      in_rx_byte,
  // result channel
  input  logic                            out_pop,
  output logic                            out_empty,
  output logic                            out_kind,
  output logic [2:0]                      out_status,
  output logic [7:0]                      out_function_code,
  output logic [8:0]                      out_frame_length,
  output logic                            out_broadcast,
  output logic [7:0]                      out_tx_byte,
  output logic                            out_last,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mbrtu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data
);

  logic                in_beat;     // accepted input beat
  logic                push;        // front end hands over a finished frame
  mbrtu_pkg::verdict_t entry;
  logic                q_full, q_empty, q_pop;
  mbrtu_pkg::verdict_t head;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign in_beat   = in_push && !q_full;

  // frame tracking and classification
  mbrtu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_beat),
    .command    (in_command),
    .rx_byte    (in_rx_byte),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .entry      (entry)
  );

  // decoupling between classification and result sequencing
  mbrtu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (entry),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  // verdict and reply byte sequencing into the output register
  mbrtu_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .head              (head),
    .q_pop             (q_pop),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_kind          (out_kind),
    .out_status        (out_status),
    .out_function_code (out_function_code),
    .out_frame_length  (out_frame_length),
    .out_broadcast     (out_broadcast),
    .out_tx_byte       (out_tx_byte),
    .out_last          (out_last)
  );

endmodule
